// ===== sv/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the sector locator.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int MAX_WALLS   = 1024;
	localparam int MAX_SECTORS = 64;
	localparam int FRAC_BITS   = 8;
	localparam int WAW         = $clog2(MAX_WALLS);
	localparam int SAW         = $clog2(MAX_SECTORS);
	localparam int WCW         = WAW + 1;
	localparam int SCW         = SAW + 1;
	localparam int WALL_W      = 64;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_CLOSE  = 2'd2,
		CMD_LOCATE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] wall_start_x;
		logic [15:0] wall_start_y;
		logic [15:0] wall_end_x;
		logic [15:0] wall_end_y;
		logic [23:0] point_x;
		logic [23:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic [5:0] sector_index;
		logic       table_overflow;
	} out_item_t;

	// Edge evaluation request from the sequencer
	typedef struct packed {
		logic               valid;
		logic signed [15:0] xi;
		logic signed [15:0] yi;
		logic signed [15:0] xj;
		logic signed [15:0] yj;
	} edge_req_t;

endpackage

// ===== sv/pip_if.sv =====
// ----------------------------------------------------------------------------
// pip_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface pip_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/point_in_polygon_sector_locate.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_sector_locate
// Wall map store and even-odd sector search.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in      | in  | command, wall coordinates, query point
// out     | out | found, sector_index, table_overflow
// Clear, add and close update the map and give no result.
// Locate scans the sectors in order; it reads each wall of a non-empty
// sector from the wall RAM, tests its edges and the closing edge, and
// reports the first sector with an odd crossing count.
// One item at a time; a held result blocks the next item.
// Reset clears counts and flags; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module point_in_polygon_sector_locate (
	input logic clk,
	input logic arst_n,
	pip_if.sink   in,
	pip_if.source out
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SEC   = 6'b000010,
		ST_SECW  = 6'b000100,
		ST_WALL  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic [pip_pkg::WCW-1:0] wall_count_q;
	logic [pip_pkg::SCW-1:0] sector_count_q;
	logic overflow_q;
	logic signed [23:0] qx_q, qy_q;
	logic [pip_pkg::SCW-1:0] sec_q;
	logic [pip_pkg::WCW-1:0] first_q, last_q, w_q;
	logic rd_q;
	logic first_rd_q;
	logic odd_q;
	logic [1:0] drain_q;
	logic signed [15:0] fx_q, fy_q, px_q, py_q;
	logic found_q;
	logic [5:0] idx_q;
	logic half_q;

	logic we;
	logic [pip_pkg::WAW-1:0] raddr;
	logic [63:0] wdata, rdata;
	logic [pip_pkg::WCW-1:0] sec_rdata;
	logic sec_we;
	pip_pkg::edge_req_t req;
	logic toggle;
	pip_pkg::in_item_t d;

	assign d = in.data;
	assign in.ready = (state_q == ST_IDLE);
	assign wdata = {d.wall_start_x, d.wall_start_y, d.wall_end_x, d.wall_end_y};
	assign we = in.valid && in.ready && d.command == pip_pkg::CMD_ADD
		&& wall_count_q < pip_pkg::WCW'(pip_pkg::MAX_WALLS);
	assign sec_we = in.valid && in.ready && d.command == pip_pkg::CMD_CLOSE
		&& sector_count_q < pip_pkg::SCW'(pip_pkg::MAX_SECTORS);
	assign raddr = w_q[pip_pkg::WAW-1:0];

	pip_ram #(.WIDTH(64), .DEPTH(pip_pkg::MAX_WALLS)) u_walls (
		.clk(clk), .we(we), .waddr(wall_count_q[pip_pkg::WAW-1:0]), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);
	pip_ram #(.WIDTH(pip_pkg::WCW), .DEPTH(pip_pkg::MAX_SECTORS)) u_secs (
		.clk(clk), .we(sec_we), .waddr(sector_count_q[pip_pkg::SAW-1:0]),
		.wdata(wall_count_q), .raddr(sec_q[pip_pkg::SAW-1:0]), .rdata(sec_rdata)
	);

	// Each wall read gives two edges: prev end->start (half 0, skipped on the
	// first wall and closed in drain) and start->end (half 1)
	always_comb begin
		req = '0;
		if (state_q == ST_WALL && rd_q) begin
			req.valid = half_q || !first_rd_q;
			if (!half_q) begin
				req.xi = $signed(rdata[63:48]); req.yi = $signed(rdata[47:32]);
				req.xj = px_q;
				req.yj = py_q;
			end else begin
				req.xi = $signed(rdata[31:16]); req.yi = $signed(rdata[15:0]);
				req.xj = $signed(rdata[63:48]); req.yj = $signed(rdata[47:32]);
			end
		end else if (state_q == ST_DRAIN && drain_q == 2'd0) begin
			// closing edge: first corner against last end
			req.valid = 1'b1;
			req.xi = fx_q; req.yi = fy_q; req.xj = px_q; req.yj = py_q;
		end
	end

	pip_edge u_edge (.clk(clk), .arst_n(arst_n), .req(req), .qx(qx_q), .qy(qy_q),
		.toggle(toggle));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wall_count_q <= '0;
			sector_count_q <= '0;
			overflow_q <= 1'b0;
			sec_q <= '0;
			first_q <= '0;
			last_q <= '0;
			w_q <= '0;
			rd_q <= 1'b0;
			first_rd_q <= 1'b0;
			odd_q <= 1'b0;
			drain_q <= '0;
			half_q <= 1'b0;
			found_q <= 1'b0;
			idx_q <= '0;
			fx_q <= '0;
			fy_q <= '0;
			px_q <= '0;
			py_q <= '0;
		end else begin
			if (toggle) odd_q <= !odd_q;
			unique case (state_q)
				ST_IDLE: begin
					if (in.valid) begin
						unique case (pip_pkg::cmd_t'(d.command))
							pip_pkg::CMD_CLEAR: begin
								wall_count_q <= '0;
								sector_count_q <= '0;
								overflow_q <= 1'b0;
							end
							pip_pkg::CMD_ADD: begin
								if (we) wall_count_q <= wall_count_q + 1'b1;
								else overflow_q <= 1'b1;
							end
							pip_pkg::CMD_CLOSE: begin
								if (sec_we) sector_count_q <= sector_count_q + 1'b1;
								else overflow_q <= 1'b1;
							end
							pip_pkg::CMD_LOCATE: begin
								sec_q <= '0;
								first_q <= '0;
								found_q <= 1'b0;
								idx_q <= '0;
								state_q <= ST_SEC;
							end
							default: ;
						endcase
					end
				end
				ST_SEC: begin
					if (sec_q >= sector_count_q) state_q <= ST_OUT;
					else state_q <= ST_SECW;
				end
				ST_SECW: begin
					last_q <= sec_rdata;
					w_q <= first_q;
					rd_q <= 1'b0;
					half_q <= 1'b0;
					first_rd_q <= 1'b1;
					odd_q <= 1'b0;
					if (sec_rdata <= first_q) begin
						first_q <= sec_rdata;
						sec_q <= sec_q + 1'b1;
						state_q <= ST_SEC;
					end else begin
						state_q <= ST_WALL;
					end
				end
				ST_WALL: begin
					if (!rd_q) begin
						rd_q <= 1'b1;
					end else if (!half_q) begin
						half_q <= 1'b1;
						if (first_rd_q) begin
							fx_q <= $signed(rdata[63:48]);
							fy_q <= $signed(rdata[47:32]);
						end
						first_rd_q <= 1'b0;
					end else begin
						half_q <= 1'b0;
						px_q <= $signed(rdata[31:16]);
						py_q <= $signed(rdata[15:0]);
						rd_q <= 1'b0;
						if (w_q + 1'b1 == last_q) begin
							drain_q <= '0;
							state_q <= ST_DRAIN;
						end else begin
							w_q <= w_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd2) begin
						if (odd_q) begin
							found_q <= 1'b1;
							idx_q <= sec_q[5:0];
							state_q <= ST_OUT;
						end else begin
							first_q <= last_q;
							sec_q <= sec_q + 1'b1;
							state_q <= ST_SEC;
						end
					end
				end
				ST_OUT: begin
					if (out.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			qx_q <= $signed(d.point_x);
			qy_q <= $signed(d.point_y);
		end
	end

	assign out.valid = (state_q == ST_OUT);
	assign out.data = '{found: found_q, sector_index: idx_q, table_overflow: overflow_q};
endmodule

// ===== sv/pip_ram.sv =====
// ----------------------------------------------------------------------------
// pip_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/pip_edge.sv =====
// ----------------------------------------------------------------------------
// pip_edge
// Registered crossing test of one polygon edge against the query point.
// ----------------------------------------------------------------------------
module pip_edge (
	input  logic                clk,
	input  logic                arst_n,
	input  pip_pkg::edge_req_t  req,
	input  logic signed [23:0]  qx,
	input  logic signed [23:0]  qy,
	output logic                toggle
);
	logic signed [24:0] xis, yis, xjs, yjs;
	logic               cand;
	logic signed [25:0] dqy, dqx;
	logic signed [16:0] dx, dy;
	logic               cand_s1, dyp_s1;
	logic signed [43:0] lhs_s1, rhs_s1;

	always_comb begin
		xis  = 25'(req.xi) <<< pip_pkg::FRAC_BITS;
		yis  = 25'(req.yi) <<< pip_pkg::FRAC_BITS;
		xjs  = 25'(req.xj) <<< pip_pkg::FRAC_BITS;
		yjs  = 25'(req.yj) <<< pip_pkg::FRAC_BITS;
		cand = ((yis < 25'(qy) && yjs >= 25'(qy)) || (yjs < 25'(qy) && yis >= 25'(qy)))
			&& (xis <= 25'(qx) || xjs <= 25'(qx));
		dqy  = 26'(qy) - 26'(yis);
		dqx  = 26'(qx) - 26'(xis);
		dx   = 17'(req.xj) - 17'(req.xi);
		dy   = 17'(req.yj) - 17'(req.yi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_s1 <= 1'b0;
		end else begin
			cand_s1 <= req.valid && cand;
		end
	end

	always_ff @(posedge clk) begin
		dyp_s1 <= dy > 17'sd0;
		lhs_s1 <= 44'(dqy) * 44'(dx);
		rhs_s1 <= 44'(dqx) * 44'(dy);
	end

	assign toggle = cand_s1 && (dyp_s1 ? (lhs_s1 < rhs_s1) : (lhs_s1 > rhs_s1));
endmodule

// ===== sv/pip_checker.sv =====
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks on the sector locator.
// ----------------------------------------------------------------------------
module pip_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_found,
	input logic [5:0] out_sector_index
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_found |-> out_sector_index == 6'd0) else $error("index not zero");
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("not idle after result");
endmodule

bind point_in_polygon_sector_locate pip_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_found(out.data.found),
	.out_sector_index(out.data.sector_index)
);

// ===== tb/sv/point_in_polygon_sector_locate_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_sector_locate_test
// Self-checking bench for the sector locator. A directed table covers the
// empty map, a simple square, the coordinate extremes, open walls and clear.
// Random maps of small polygons are then built and queried. The random part
// runs with varying idle and stall rates, and with a long output hold-off.
// The sector table is overrun at the end.
// Each locate result is checked against a fixed expected result or an in-bench even-odd predictor.
// ----------------------------------------------------------------------------
module point_in_polygon_sector_locate_test;
	import pip_pkg::*;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} stim_t;

	logic clk;
	logic arst_n;

	pip_if #(.T(in_item_t))  in_ch ();
	pip_if #(.T(out_item_t)) out_ch ();

	point_in_polygon_sector_locate i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch.sink),
		.out    (out_ch.source)
	);

	// predictor state
	logic signed [15:0] map_walls [MAX_WALLS][4];
	int unsigned        map_sector_end [MAX_SECTORS];
	int unsigned        map_wall_count;
	int unsigned        map_sector_count;
	bit                 map_overflow;

	out_item_t pending_locates [$];
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_left;
	int        errors;
	int        locates_sent;
	int        hits_seen;
	longint    cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("[point_in_polygon_sector_locate] ERROR");
				$finish;
			end
		end
	end

	function automatic bit poly_contains(int unsigned first, int unsigned last,
			longint qx, longint qy);
		longint xi, yi, xj, yj, dy, lhs, rhs, sc;
		int unsigned n, j, ki, kj;
		bit odd;
		bit cr;
		odd = 0;
		sc = longint'(1) << FRAC_BITS;
		if (last <= first) return 0;
		n = 2 * (last - first);
		j = n - 1;
		for (int unsigned i = 0; i < n; i++) begin
			ki = 2 * first + i;
			kj = 2 * first + j;
			xi = map_walls[ki >> 1][(ki & 1) ? 2 : 0];
			yi = map_walls[ki >> 1][(ki & 1) ? 3 : 1];
			xj = map_walls[kj >> 1][(kj & 1) ? 2 : 0];
			yj = map_walls[kj >> 1][(kj & 1) ? 3 : 1];
			if (((yi * sc < qy && yj * sc >= qy) || (yj * sc < qy && yi * sc >= qy))
					&& (xi * sc <= qx || xj * sc <= qx)) begin
				dy  = yj - yi;
				lhs = (qy - yi * sc) * (xj - xi);
				rhs = (qx - xi * sc) * dy;
				cr  = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
				if (cr) odd = !odd;
			end
			j = i;
		end
		return odd;
	endfunction

	function automatic out_item_t locate_sector(in_item_t it);
		out_item_t   r;
		longint      qx, qy;
		int unsigned first, last;
		qx = longint'($signed(it.point_x));
		qy = longint'($signed(it.point_y));
		first = 0;
		r = '0;
		for (int unsigned s = 0; s < map_sector_count; s++) begin
			last = map_sector_end[s];
			if (poly_contains(first, last, qx, qy)) begin
				r.found = 1'b1;
				r.sector_index = s[5:0];
				break;
			end
			first = last;
		end
		r.table_overflow = map_overflow;
		return r;
	endfunction

	task automatic apply_item(stim_t s);
		case (cmd_t'(s.item.command))
			CMD_CLEAR: begin
				map_wall_count   = 0;
				map_sector_count = 0;
				map_overflow     = 0;
			end
			CMD_ADD: begin
				if (map_wall_count < MAX_WALLS) begin
					map_walls[map_wall_count][0] = s.item.wall_start_x;
					map_walls[map_wall_count][1] = s.item.wall_start_y;
					map_walls[map_wall_count][2] = s.item.wall_end_x;
					map_walls[map_wall_count][3] = s.item.wall_end_y;
					map_wall_count++;
				end else
					map_overflow = 1;
			end
			CMD_CLOSE: begin
				if (map_sector_count < MAX_SECTORS) begin
					map_sector_end[map_sector_count] = map_wall_count;
					map_sector_count++;
				end else
					map_overflow = 1;
			end
			default: begin
				locates_sent++;
				pending_locates.insert(pending_locates.size(),
					s.typed ? s.want : locate_sector(s.item));
			end
		endcase
	endtask

	task automatic send(stim_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= s.item;
		do @(posedge clk); while (!in_ch.ready);
		apply_item(s);
	endtask

	function automatic stim_t mk(cmd_t c, int ax, int ay, int bx, int by,
			int px, int py);
		stim_t s;
		s.item.command      = c;
		s.item.wall_start_x = ax[15:0];
		s.item.wall_start_y = ay[15:0];
		s.item.wall_end_x   = bx[15:0];
		s.item.wall_end_y   = by[15:0];
		s.item.point_x      = px[23:0];
		s.item.point_y      = py[23:0];
		s.typed = 0;
		s.want  = '0;
		return s;
	endfunction

	function automatic stim_t mk_want(stim_t s, bit f, int idx, bit ovf);
		s.typed = 1;
		s.want.found = f;
		s.want.sector_index = idx[5:0];
		s.want.table_overflow = ovf;
		return s;
	endfunction

	function automatic stim_t noise();
		stim_t        s;
		logic [127:0] r;
		r = {$urandom, $urandom, $urandom, $urandom};
		s.item = r[$bits(in_item_t)-1:0];
		s.typed = 0;
		s.want  = '0;
		return s;
	endfunction

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_locates.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	// build a small map, then query around it
	task automatic random_map(int budget);
		int x0, y0, w, h, nsec, nw, sent;
		stim_t s;
		sent = 0;
		if (map_wall_count > 200 || map_sector_count > 50 || $urandom_range(3) != 0)
			send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		nsec = $urandom_range(1, 5);
		for (int k = 0; k < nsec; k++) begin
			x0 = $urandom_range(0, 400) - 200;
			y0 = $urandom_range(0, 400) - 200;
			w  = $urandom_range(1, 60);
			h  = $urandom_range(1, 60);
			case ($urandom_range(3))
				0: ;
				1, 2: begin
					send(mk(CMD_ADD, x0, y0, x0 + w, y0, 0, 0));
					send(mk(CMD_ADD, x0 + w, y0 + h, x0, y0 + h, 0, 0));
				end
				default: begin
					nw = $urandom_range(1, 3);
					for (int m = 0; m < nw; m++)
						send(mk(CMD_ADD, x0 + $urandom_range(0, w), y0 + $urandom_range(0, h),
							x0 + $urandom_range(0, w), y0 + $urandom_range(0, h), 0, 0));
				end
			endcase
			send(mk(CMD_CLOSE, 0, 0, 0, 0, 0, 0));
		end
		while (sent < budget) begin
			case ($urandom_range(9))
				0: s = noise();
				1: s = mk(CMD_LOCATE, 0, 0, 0, 0, $urandom, $urandom);
				default: s = mk(CMD_LOCATE, 0, 0, 0, 0,
					($urandom_range(0, 400) - 200) * 256 + $urandom_range(0, 255) - 128,
					($urandom_range(0, 400) - 200) * 256 + $urandom_range(0, 255) - 128);
			endcase
			send(s);
			sent++;
		end
	endtask

	task automatic random_phase(int idle, int stall, int n);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		for (int k = 0; k < n; k += 8) random_map(8);
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_locates.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_ch.data);
				errors++;
			end else begin
				e = pending_locates.pop_front();
				if (out_ch.data.found !== e.found) begin
					$display("%0t: found expected %0d actual %0d", $time, e.found,
						out_ch.data.found);
					errors++;
				end
				if (out_ch.data.sector_index !== e.sector_index) begin
					$display("%0t: sector_index expected %0d actual %0d", $time,
						e.sector_index, out_ch.data.sector_index);
					errors++;
				end
				if (out_ch.data.table_overflow !== e.table_overflow) begin
					$display("%0t: table_overflow expected %0d actual %0d", $time,
						e.table_overflow, out_ch.data.table_overflow);
					errors++;
				end
				if (e.found) hits_seen++;
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		stim_t table_rows [$];
		errors = 0;
		locates_sent = 0;
		hits_seen = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		map_wall_count = 0;
		map_sector_count = 0;
		map_overflow = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		table_rows = '{
			mk_want(mk(CMD_LOCATE, 0, 0, 0, 0, 0, 0), 0, 0, 0),
			mk(CMD_CLOSE, 0, 0, 0, 0, 0, 0),
			mk(CMD_ADD, 0, 0, 10, 0, 0, 0),
			mk(CMD_ADD, 10, 10, 0, 10, 0, 0),
			mk(CMD_CLOSE, 0, 0, 0, 0, 0, 0),
			mk_want(mk(CMD_LOCATE, 0, 0, 0, 0, 1280, 1280), 1, 1, 0),
			mk(CMD_LOCATE, 0, 0, 0, 0, -8388608, -8388608),
			mk(CMD_LOCATE, 0, 0, 0, 0, 8388607, 8388607),
			mk(CMD_LOCATE, 0, 0, 0, 0, 0, 0),
			mk(CMD_LOCATE, 0, 0, 0, 0, 2560, 2560),
			mk(CMD_ADD, -32768, -32768, 32767, -32768, 0, 0),
			mk(CMD_ADD, 32767, 32767, -32768, 32767, 0, 0),
			mk(CMD_LOCATE, 0, 0, 0, 0, 25600, 25600),
			mk(CMD_CLOSE, 0, 0, 0, 0, 0, 0),
			mk(CMD_LOCATE, 0, 0, 0, 0, 25600, 25600),
			mk(CMD_LOCATE, 0, 0, 0, 0, 1408, 1408),
			mk(CMD_LOCATE, 0, 0, 0, 0, -8388608, 8388607),
			mk(CMD_LOCATE, 0, 0, 0, 0, 8388607, -8388608),
			mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0),
			mk_want(mk(CMD_LOCATE, 0, 0, 0, 0, 1280, 1280), 0, 0, 0)
		};
		foreach (table_rows[k]) send(table_rows[k]);
		drain();

		random_phase(0, 0, 24);
		random_phase(52, 0, 24);
		// hold the output while items keep coming
		hold_left = 400;
		random_phase(0, 52, 24);
		drain();
		random_phase(9, 9, 24);
		drain();

		// overrun the sector table, last slot holds a square
		send_idle_pct = 0;
		recv_stall_pct = 20;
		send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		for (int k = 0; k < MAX_SECTORS - 1; k++) send(mk(CMD_CLOSE, 0, 0, 0, 0, 0, 0));
		send(mk(CMD_ADD, 0, 0, 10, 0, 0, 0));
		send(mk(CMD_ADD, 10, 10, 0, 10, 0, 0));
		for (int k = 0; k < 3; k++) send(mk(CMD_CLOSE, 0, 0, 0, 0, 0, 0));
		send(mk_want(mk(CMD_LOCATE, 0, 0, 0, 0, 1280, 1280), 1, 63, 1));
		send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		send(mk_want(mk(CMD_LOCATE, 0, 0, 0, 0, 1280, 1280), 0, 0, 0));
		drain();

		$display("Covered %0d locate queries (%0d hits) over directed, random and",
			locates_sent, hits_seen);
		$display("capacity-overrun maps, with input idling and output stalls.");
		if (errors == 0 && pending_locates.size() == 0)
			$display("[point_in_polygon_sector_locate] OK");
		else
			$display("[point_in_polygon_sector_locate] ERROR");
		$finish;
	end

endmodule
